FILE: hw/rtl/ltts_pkg.sv
// ltts_pkg: shared types, sizes and register indexes for the leading-track
// toward-region pt sum block. No dependencies.
package ltts_pkg;

  localparam int MAX_TRACKS = 128;
  localparam int ADDR_W     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

  localparam int PT_W       = 16;
  localparam int ETA_W      = 14;
  localparam int PHI_W      = 16;
  localparam int SCALE_W    = 16;
  localparam int SUM_OUT_W  = 23;
  localparam int COUNT_W    = 8;

  // raw pt sum over a full store
  localparam int SUM_W      = PT_W + CNT_W;
  localparam int PROD_W     = SUM_W + SCALE_W;
  localparam int SCL_W      = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int CNTX_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic [SUM_OUT_W-1:0] SUM_MAX   = {SUM_OUT_W{1'b1}};
  localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [PHI_W:0] PHI_HALF = (PHI_W + 1)'(1) << (PHI_W - 1);
  localparam logic [PHI_W:0] PHI_FULL = (PHI_W + 1)'(1) << PHI_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DPHI_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_MIN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_MAX    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_SCALE  = 8'd3;

  localparam logic [PHI_W-1:0]          DPHI_LIMIT_RST = 16'd10923;
  localparam logic signed [ETA_W-1:0]   ETA_MIN_RST    = -14'sd2500;
  localparam logic signed [ETA_W-1:0]   ETA_MAX_RST    = 14'sd2500;
  localparam logic [SCALE_W-1:0]        SUM_SCALE_RST  = 16'd12517;

  typedef struct packed {
    logic [PHI_W-1:0]        phi;
    logic signed [ETA_W-1:0] eta;
    logic [PT_W-1:0]         pt;
  } track_t;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_READ,
    S_ACCUM,
    S_SCALE,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/ltts_track_store.sv
// ltts_track_store: track memory, one write port and one registered read port.
// Depends on ltts_pkg.
module ltts_track_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ltts_pkg::ADDR_W-1:0]  wr_addr,
  input  ltts_pkg::track_t             wr_data,
  input  logic                         rd_en,
  input  logic [ltts_pkg::ADDR_W-1:0]  rd_addr,
  output ltts_pkg::track_t             rd_data
);
  import ltts_pkg::*;

  track_t mem [MAX_TRACKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/leading_track_toward_sum.sv
// leading_track_toward_sum: top level, event sequencer, shared compare and
// accumulate unit, scaling and result register. Depends on ltts_pkg and
// ltts_track_store.
//
//  channel   direction  handshake                 contents
//  s_*       in         s_tvalid / s_tready       one track, s_tlast closes the event
//  m_*       out        m_tvalid / m_tready       one result per event
//  cfg_*     in         cfg_valid / cfg_ready     register index and data
//
// each track is taken on its handshake while collecting. after the closing track
// the store is walked one stored track at a time: a memory read state, then a
// state for the shared compare and add. then the scale state registers the
// product and the done state loads the result, with s_tready low meanwhile.
// the result waits in its own register; a finished event holds in the last
// step only while the previous result is still untaken. rst is synchronous.
module leading_track_toward_sum (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [47:0]                     s_tdata,   // pt, eta, phi, zero pad
  input  logic                            s_tlast,   // last_track
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [47:0]                     m_tdata,   // leading_pt, toward_sum, track_count, zero pad
  output logic                            m_tuser,   // overflow
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ltts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data
);
  import ltts_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]        count;
  logic [PT_W-1:0]         lead_pt;
  logic [PHI_W-1:0]        lead_phi;
  logic                    ovf;
  logic [CNT_W-1:0]        idx;
  logic [SUM_W-1:0]        acc;
  logic [PROD_W-1:0]       prod;

  logic [PHI_W-1:0]        dphi_limit;
  logic signed [ETA_W-1:0] eta_min;
  logic signed [ETA_W-1:0] eta_max;
  logic [SCALE_W-1:0]      sum_scale;

  logic [SUM_OUT_W-1:0]    res_sum;
  logic [PT_W-1:0]         res_lead;
  logic [COUNT_W-1:0]      res_count;
  logic                    res_ovf;

  track_t                  in_trk;
  track_t                  rd_trk;
  logic                    s_acc;
  logic                    store_wr;
  logic                    rd_en;
  logic                    load_out;

  logic [PHI_W:0]          diff;
  logic [PHI_W:0]          dphi;
  logic                    hit;
  logic [SCL_W-1:0]        scaled;
  logic [CNTX_W-1:0]       cnt_x;

  assign in_trk.pt  = s_tdata[15:0];
  assign in_trk.eta = s_tdata[29:16];
  assign in_trk.phi = s_tdata[45:30];

  assign s_tready  = (state == S_COLLECT) && !rst;
  assign s_acc     = s_tvalid && s_tready;
  assign store_wr  = s_acc && (count < CNT_W'(MAX_TRACKS));
  assign cfg_ready = !rst;

  ltts_track_store u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (in_trk),
    .rd_en   (rd_en),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_trk)
  );

  // wrapped azimuth distance and window test of the track just read
  always_comb begin
    diff = {1'b0, rd_trk.phi} - {1'b0, lead_phi};
    dphi = diff[PHI_W] ? (~diff + (PHI_W + 1)'(1)) : diff;
    if (dphi > PHI_HALF) begin
      dphi = PHI_FULL - dphi;
    end
    hit = (dphi < {1'b0, dphi_limit}) &&
          ($signed(rd_trk.eta) > eta_min) && ($signed(rd_trk.eta) < eta_max);
  end

  always_comb begin
    scaled = SCL_W'(prod >> SCALE_W);
    if (scaled > SCL_W'(SUM_MAX)) begin
      scaled = SCL_W'(SUM_MAX);
    end
    cnt_x = CNTX_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_COLLECT: begin
        if (s_acc && s_tlast) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (idx == count) begin
          state_next = S_SCALE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_ACCUM;
        end
      end
      S_ACCUM: begin
        state_next = S_READ;
      end
      S_SCALE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_COLLECT;
        end
      end
      default: state_next = S_COLLECT;
    endcase
  end

  // event state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      lead_pt  <= '0;
      lead_phi <= '0;
      ovf      <= 1'b0;
      idx      <= '0;
      acc      <= '0;
    end else if (load_out) begin
      count    <= '0;
      lead_pt  <= '0;
      lead_phi <= '0;
      ovf      <= 1'b0;
      idx      <= '0;
      acc      <= '0;
    end else begin
      if (store_wr) begin
        count <= count + CNT_W'(1);
        if (count == '0 || in_trk.pt > lead_pt) begin
          lead_pt  <= in_trk.pt;
          lead_phi <= in_trk.phi;
        end
      end else if (s_acc) begin
        ovf <= 1'b1;
      end
      if (state == S_ACCUM) begin
        idx <= idx + CNT_W'(1);
        if (hit) begin
          acc <= acc + SUM_W'(rd_trk.pt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCALE) begin
      prod <= PROD_W'(acc) * PROD_W'(sum_scale);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_lead  <= lead_pt;
      res_sum   <= scaled[SUM_OUT_W-1:0];
      res_count <= (cnt_x > CNTX_W'(COUNT_MAX)) ? COUNT_MAX : cnt_x[COUNT_W-1:0];
      res_ovf   <= ovf;
    end
  end

  assign m_tdata = {1'b0, res_count, res_sum, res_lead};
  assign m_tuser = res_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      dphi_limit <= DPHI_LIMIT_RST;
      eta_min    <= ETA_MIN_RST;
      eta_max    <= ETA_MAX_RST;
      sum_scale  <= SUM_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DPHI_LIMIT: dphi_limit <= cfg_data;
        REG_ETA_MIN:    eta_min    <= cfg_data[ETA_W-1:0];
        REG_ETA_MAX:    eta_max    <= cfg_data[ETA_W-1:0];
        REG_SUM_SCALE:  sum_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
